// ----- rtl/afp_pkg.sv -----
// Package: shared types, codes and constants of the adaptive frame pacer.
`default_nettype none

package afp_pkg;

    // Defaults for the top-level parameters
    localparam int CYCLE_FRAMES_DEF = 5;
    localparam int TIME_BITS_DEF    = 48;

    // Field widths
    localparam int NOW_W     = 48;
    localparam int PERIOD_W  = 20;
    localparam int PCT_W     = 7;
    localparam int WAIT_W    = 20;
    localparam int CWAIT_W   = 24;
    localparam int COUNT_W   = 32;
    localparam int FIC_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = PERIOD_W;

    // Threshold product period * pct * cycle frames; 31 bits cover the largest cycle length
    localparam int THR_W = 31;
    // Scaled compare 100 * (v + 1) <= threshold product
    localparam int CMP_W = THR_W + 7;
    localparam int PCT_SCALE = 100;

    // Saturation limits
    localparam logic [FIC_W-1:0]   FIC_MAX   = '1;
    localparam logic [WAIT_W-1:0]  WAIT_MAX  = '1;
    localparam logic [CWAIT_W-1:0] CWAIT_MAX = '1;

    // Register reset values
    localparam int PERIOD_RST = 16666;
    localparam int MPCT_RST   = 50;
    localparam int APCT_RST   = 20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_PCT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTOPILOT_PCT = 2'd2;

    // Request types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    // Status codes
    localparam logic STAT_OK       = 1'b0;
    localparam logic STAT_BACKWARD = 1'b1;

    // Pacing modes
    localparam logic MODE_AUTO   = 1'b0;
    localparam logic MODE_MANUAL = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [NOW_W-1:0] now_us;
    } afp_in_t;

    typedef struct packed {
        logic               status;
        logic               mode;
        logic [WAIT_W-1:0]  wait_us;
        logic [COUNT_W-1:0] frames_total;
        logic [COUNT_W-1:0] frames_auto;
        logic [COUNT_W-1:0] frames_manual;
    } afp_out_t;

    // Live configuration handed to the step logic
    typedef struct packed {
        logic [PERIOD_W-1:0] frame_period_us;
        logic [THR_W-1:0]    thr_manual;
        logic [THR_W-1:0]    thr_auto;
    } afp_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/afp_cfg.sv -----
// Configuration registers and precomputed mode-switch threshold products.
`default_nettype none

module afp_cfg #(
    parameter int CYCLE_FRAMES = afp_pkg::CYCLE_FRAMES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [afp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [afp_pkg::CFG_DAT_W-1:0] cfg_data,
    output afp_pkg::afp_cfg_t                  cfg
);

    localparam logic [afp_pkg::THR_W-1:0] THR_M_RST =
        afp_pkg::THR_W'(afp_pkg::PERIOD_RST * afp_pkg::MPCT_RST * CYCLE_FRAMES);
    localparam logic [afp_pkg::THR_W-1:0] THR_A_RST =
        afp_pkg::THR_W'(afp_pkg::PERIOD_RST * afp_pkg::APCT_RST * CYCLE_FRAMES);

    logic [afp_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [afp_pkg::PCT_W-1:0]    mpct_reg, mpct_next;
    logic [afp_pkg::PCT_W-1:0]    apct_reg, apct_next;
    logic [afp_pkg::THR_W-1:0]    thr_m_reg, thr_m_next;
    logic [afp_pkg::THR_W-1:0]    thr_a_reg, thr_a_next;

    always_comb
    begin
        period_next = period_reg;
        mpct_next   = mpct_reg;
        apct_next   = apct_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                afp_pkg::REG_FRAME_PERIOD:  period_next = cfg_data;
                afp_pkg::REG_MANUAL_PCT:    mpct_next = cfg_data[afp_pkg::PCT_W-1:0];
                afp_pkg::REG_AUTOPILOT_PCT: apct_next = cfg_data[afp_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
        // Expected cycle time times percent; the /100 is folded into the compare
        thr_m_next = afp_pkg::THR_W'(32'(period_next) * 32'(mpct_next) * 32'(CYCLE_FRAMES));
        thr_a_next = afp_pkg::THR_W'(32'(period_next) * 32'(apct_next) * 32'(CYCLE_FRAMES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= afp_pkg::PERIOD_W'(afp_pkg::PERIOD_RST);
            mpct_reg   <= afp_pkg::PCT_W'(afp_pkg::MPCT_RST);
            apct_reg   <= afp_pkg::PCT_W'(afp_pkg::APCT_RST);
            thr_m_reg  <= THR_M_RST;
            thr_a_reg  <= THR_A_RST;
        end
        else
        begin
            period_reg <= period_next;
            mpct_reg   <= mpct_next;
            apct_reg   <= apct_next;
            thr_m_reg  <= thr_m_next;
            thr_a_reg  <= thr_a_next;
        end
    end

    assign cfg.frame_period_us = period_reg;
    assign cfg.thr_manual      = thr_m_reg;
    assign cfg.thr_auto        = thr_a_reg;

endmodule

`default_nettype wire

// ----- rtl/afp_core.sv -----
// Pacer state and the single-pass step logic for one word.
`default_nettype none

module afp_core #(
    parameter int CYCLE_FRAMES = afp_pkg::CYCLE_FRAMES_DEF,
    parameter int TIME_BITS    = afp_pkg::TIME_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire afp_pkg::afp_cfg_t cfg,
    input  wire afp_pkg::afp_in_t  item,
    input  wire logic              advance,
    output afp_pkg::afp_out_t      result
);

    localparam int TB = TIME_BITS;

    logic                        mode_reg, mode_next;
    logic [TB-1:0]               deadline_reg, deadline_next;
    logic [TB-1:0]               cstart_reg, cstart_next;
    logic [afp_pkg::FIC_W-1:0]   fic_reg, fic_next;
    logic [afp_pkg::CWAIT_W-1:0] cw_reg, cw_next;
    logic [afp_pkg::COUNT_W-1:0] total_reg, total_next;
    logic [afp_pkg::COUNT_W-1:0] auto_reg, auto_next;
    logic [afp_pkg::COUNT_W-1:0] manual_reg, manual_next;

    logic [TB-1:0]               now, period, elapsed, now_plus_p;
    logic [TB-1:0]               dl_eff, dl_diff, dl_adv, dl_new, t_end, wait_full;
    logic [afp_pkg::CMP_W-1:0]   el_scaled, cw_scaled;
    logic                        due, backward, recon, el_below, cw_below;
    logic                        engage, release_auto, mode_eff, ahead;
    logic [afp_pkg::CWAIT_W-1:0] cw_eff, wait24, cw_acc;
    logic [afp_pkg::CWAIT_W:0]   acc;
    logic [afp_pkg::WAIT_W-1:0]  wait20, wait_out;
    logic                        status;

    always_comb
    begin
        now    = TB'(item.now_us);
        period = TB'(cfg.frame_period_us);

        due      = fic_reg >= afp_pkg::FIC_W'(CYCLE_FRAMES);
        backward = now < cstart_reg;
        recon    = due && !backward;

        // elapsed < floor(thr / 100)  <=>  100 * elapsed + 100 <= thr
        elapsed   = now - cstart_reg;
        el_scaled = afp_pkg::CMP_W'(elapsed[afp_pkg::THR_W-1:0]) *
                    afp_pkg::CMP_W'(afp_pkg::PCT_SCALE) + afp_pkg::CMP_W'(afp_pkg::PCT_SCALE);
        el_below  = (elapsed[TB-1:afp_pkg::THR_W] == '0) &&
                    (el_scaled <= afp_pkg::CMP_W'(cfg.thr_manual));
        cw_scaled = afp_pkg::CMP_W'(cw_reg) * afp_pkg::CMP_W'(afp_pkg::PCT_SCALE) +
                    afp_pkg::CMP_W'(afp_pkg::PCT_SCALE);
        cw_below  = cw_scaled <= afp_pkg::CMP_W'(cfg.thr_auto);

        engage       = recon && (mode_reg == afp_pkg::MODE_AUTO) && el_below;
        release_auto = recon && (mode_reg == afp_pkg::MODE_MANUAL) && cw_below;
        if (engage)
            mode_eff = afp_pkg::MODE_MANUAL;
        else if (release_auto)
            mode_eff = afp_pkg::MODE_AUTO;
        else
            mode_eff = mode_reg;
        cw_eff = recon ? '0 : cw_reg;

        // Deadline handling in manual pacing
        now_plus_p = now + period;
        dl_eff     = engage ? now_plus_p : deadline_reg;
        ahead      = now < dl_eff;
        dl_diff    = dl_eff - now;
        t_end      = ahead ? dl_eff : now;
        dl_adv     = dl_eff + period;
        dl_new     = (dl_adv < t_end) ? (ahead ? dl_adv : now_plus_p) : dl_adv;
        wait_full  = ahead ? dl_diff : '0;

        wait24 = (wait_full[TB-1:afp_pkg::CWAIT_W] != '0) ? afp_pkg::CWAIT_MAX :
                 wait_full[afp_pkg::CWAIT_W-1:0];
        acc    = {1'b0, cw_eff} + {1'b0, wait24};
        cw_acc = acc[afp_pkg::CWAIT_W] ? afp_pkg::CWAIT_MAX : acc[afp_pkg::CWAIT_W-1:0];
        wait20 = (wait_full[TB-1:afp_pkg::WAIT_W] != '0) ? afp_pkg::WAIT_MAX :
                 wait_full[afp_pkg::WAIT_W-1:0];

        mode_next     = mode_reg;
        deadline_next = deadline_reg;
        cstart_next   = cstart_reg;
        fic_next      = fic_reg;
        cw_next       = cw_reg;
        total_next    = total_reg;
        auto_next     = auto_reg;
        manual_next   = manual_reg;
        status        = afp_pkg::STAT_OK;
        wait_out      = '0;

        if (item.req_type == afp_pkg::REQ_START)
        begin
            mode_next     = afp_pkg::MODE_AUTO;
            deadline_next = now;
            cstart_next   = now;
            fic_next      = '0;
            cw_next       = '0;
            total_next    = '0;
            auto_next     = '0;
            manual_next   = '0;
        end
        else
        begin
            total_next = total_reg + 1'b1;
            fic_next   = (fic_reg != afp_pkg::FIC_MAX) ? fic_reg + 1'b1 : fic_reg;
            if (due && backward)
            begin
                // Hold mode and cycle start; only the total and frame-in-cycle counts move
                status = afp_pkg::STAT_BACKWARD;
            end
            else
            begin
                if (recon)
                begin
                    cstart_next = now;
                    fic_next    = '0;
                end
                mode_next     = mode_eff;
                deadline_next = dl_eff;
                cw_next       = cw_eff;
                if (mode_eff == afp_pkg::MODE_AUTO)
                begin
                    auto_next = auto_reg + 1'b1;
                end
                else
                begin
                    manual_next   = manual_reg + 1'b1;
                    deadline_next = dl_new;
                    wait_out      = wait20;
                    if (ahead)
                        cw_next = cw_acc;
                end
            end
        end

        result.status        = status;
        result.mode          = mode_next;
        result.wait_us       = wait_out;
        result.frames_total  = total_next;
        result.frames_auto   = auto_next;
        result.frames_manual = manual_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= afp_pkg::MODE_AUTO;
            deadline_reg <= '0;
            cstart_reg   <= '0;
            fic_reg      <= '0;
            cw_reg       <= '0;
            total_reg    <= '0;
            auto_reg     <= '0;
            manual_reg   <= '0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            deadline_reg <= deadline_next;
            cstart_reg   <= cstart_next;
            fic_reg      <= fic_next;
            cw_reg       <= cw_next;
            total_reg    <= total_next;
            auto_reg     <= auto_next;
            manual_reg   <= manual_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/adaptive_frame_pacer_top.sv -----
// Top level of the adaptive frame pacer: handshake, input and result registers.
`default_nettype none

// Adaptive frame pacer. A start word (req_type 0) resets pacing to autopilot at
// the given microsecond time; each frame word (req_type 1) returns exactly one
// result word with status, mode, the wait to the next deadline (manual pacing
// only) and three wrapping frame counters. Every CYCLE_FRAMES frames plus one,
// the pacer reconsiders its mode from the elapsed cycle time and the waiting it
// accumulated, against thresholds set by the frame period and the two percent
// registers. Throughput is one word per clock unless the output stalls: a word
// is taken into the input register and passes one short compare-and-add step
// into the result register, from which it leaves on the result channel.
// The step logic is the only thing between the two registers, so it sets the
// clock rate; the threshold products are registered alongside the configuration
// registers. Write the configuration port only while no word is in flight. A
// stall on the output holds the result register and then the input register;
// in_stall rises only when both are full.

module adaptive_frame_pacer_top #(
    parameter int CYCLE_FRAMES = afp_pkg::CYCLE_FRAMES_DEF,
    parameter int TIME_BITS    = afp_pkg::TIME_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire afp_pkg::afp_in_t              in_word,
    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output afp_pkg::afp_out_t                  out_word,
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [afp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [afp_pkg::CFG_DAT_W-1:0] cfg_data
);

    afp_pkg::afp_cfg_t cfg;
    afp_pkg::afp_in_t  s1_word_reg;
    afp_pkg::afp_out_t out_word_reg;
    afp_pkg::afp_out_t step_result;

    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_open, advance, in_fire;

    // Result register can take a word when empty or being drained
    assign out_open = !out_valid_reg || !out_stall;
    // Move the held word through the step logic; pacer state commits here
    assign advance  = s1_valid_reg && out_open;
    assign in_stall = s1_valid_reg && !out_open;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        out_valid_next = out_open ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on their handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_word_reg <= in_word;
        if (advance)
            out_word_reg <= step_result;
    end

    afp_cfg #(
        .CYCLE_FRAMES (CYCLE_FRAMES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afp_core #(
        .CYCLE_FRAMES (CYCLE_FRAMES),
        .TIME_BITS    (TIME_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (s1_word_reg),
        .advance (advance),
        .result  (step_result)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire
